>>> hdl/atf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atf_pkg
// Constants, codes and controller/datapath link types of the adaptive
// threshold area force unit.
// ----------------------------------------------------------------------------
package atf_pkg;

    localparam int FRAME_WIDTH    = 640;
    localparam int FRAME_HEIGHT   = 480;
    localparam int WARMUP_FRAMES  = 200;
    localparam int BASE_THRESHOLD = 120;

    localparam int HIST_DEPTH = 256;
    localparam int HIST_WIDTH = 19;
    localparam int DIV_NUM_W  = 52;
    localparam int DIV_DEN_W  = 32;

    localparam logic [31:0] EMA_KEEP   = 32'd16772552;  // 2^24 - 4664
    localparam logic [31:0] EMA_WEIGHT = 32'd4664;
    localparam logic [7:0]  THRESH_MIN = 8'd80;
    localparam logic [7:0]  THRESH_MAX = 8'd180;
    localparam logic [18:0] CNT_MAX    = 19'h7FFFF;
    localparam logic [26:0] SUM_MAX    = 27'h7FFFFFF;
    localparam logic [16:0] ONE_Q16    = 17'h10000;

    typedef enum logic [2:0] {
        CFG_ROI_LEFT   = 3'd0,
        CFG_ROI_TOP    = 3'd1,
        CFG_ROI_WIDTH  = 3'd2,
        CFG_ROI_HEIGHT = 3'd3,
        CFG_BASELINE   = 3'd4,
        CFG_AREA_ALPHA = 3'd5,
        CFG_GAIN_K     = 3'd6,
        CFG_OFFSET_B   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MUL_EMA_OLD,
        MUL_EMA_NEW,
        MUL_AREA_NEW,
        MUL_AREA_OLD,
        MUL_K_HI,
        MUL_K_LO
    } t_mul_sel;

    typedef struct packed {
        logic     accept;
        logic     hist_wr;
        logic     area_clr;
        logic     div_start;
        logic     div_thr;
        t_mul_sel mul_sel;
        logic     acc_load;
        logic     acc_shift;
        logic     ema_upd;
        logic     thr_upd;
        logic     walk;
        logic     walk_sum;
        logic     frame_clr;
        logic     sm_upd;
        logic     f_upd;
    } t_cmd;

    typedef struct packed {
        logic fend;
        logic count_nz;
        logic thr_go;
        logic div_done;
        logic walk_last;
    } t_status;

endpackage

>>> hdl/atf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module atf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/atf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atf_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [atf_pkg::DIV_NUM_W-1:0]  i_dividend,
    input  logic [atf_pkg::DIV_DEN_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [atf_pkg::DIV_NUM_W-1:0]  o_quotient
);

    localparam int NW = atf_pkg::DIV_NUM_W;
    localparam int DW = atf_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_shift;
    logic          w_ge;

    assign w_shift = {r_rem[DW-1:0], r_quo[NW-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_shift - {1'b0, r_den} : w_shift;
                r_quo <= {r_quo[NW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hdl/atf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atf_dp
// Datapath: configuration, window sums, histogram, divider, shared
// multiplier and frame-end arithmetic.
// ----------------------------------------------------------------------------
module atf_dp #(
    parameter int FRAME_WIDTH    = atf_pkg::FRAME_WIDTH,
    parameter int FRAME_HEIGHT   = atf_pkg::FRAME_HEIGHT,
    parameter int WARMUP_FRAMES  = atf_pkg::WARMUP_FRAMES,
    parameter int BASE_THRESHOLD = atf_pkg::BASE_THRESHOLD
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic [7:0]            i_pixel_value,
    input  logic [9:0]            i_column,
    input  logic [8:0]            i_row,
    input  logic                  i_inside_mask,
    input  logic                  i_frame_end,
    input  atf_pkg::t_cmd         i_cmd,
    output atf_pkg::t_status      o_status,
    output logic [18:0]           o_area_count,
    output logic [34:0]           o_smoothed_area,
    output logic signed [47:0]    o_force_value,
    output logic [7:0]            o_threshold_used,
    output logic [31:0]           o_brightness,
    output logic                  o_baseline_ready
);

    localparam int AW = $clog2(atf_pkg::HIST_DEPTH);
    localparam int HW = atf_pkg::HIST_WIDTH;

    logic [9:0]  r_left, r_width;
    logic [8:0]  r_top, r_height;
    logic [16:0] r_alpha;
    logic signed [31:0] r_gain, r_offset;

    logic [26:0] r_sum;
    logic [18:0] r_count;
    logic [31:0] r_bright, r_base;
    logic        r_known;
    logic [7:0]  r_seen, r_thr;
    logic [34:0] r_mem_area;
    logic [7:0]  r_pix;
    logic        r_mask, r_fend;
    logic [AW-1:0] r_wcnt, r_prev;
    logic        r_acc_on;
    logic [18:0] r_area;
    logic signed [60:0] r_prod;
    logic signed [63:0] r_acc;

    logic [18:0] r_o_area;
    logic [34:0] r_o_sm;
    logic signed [47:0] r_o_force;
    logic [7:0]  r_o_thr;
    logic [31:0] r_o_bright;
    logic        r_o_known;

    // window bounds, clipped at the frame edge
    logic [12:0] w_right, w_bottom, w_rsum, w_bsum;
    logic        w_in_win;
    assign w_rsum   = 13'(r_left) + 13'(r_width);
    assign w_bsum   = 13'(r_top) + 13'(r_height);
    assign w_right  = (w_rsum > 13'(FRAME_WIDTH)) ? 13'(FRAME_WIDTH) : w_rsum;
    assign w_bottom = (w_bsum > 13'(FRAME_HEIGHT)) ? 13'(FRAME_HEIGHT) : w_bsum;
    assign w_in_win = (i_column >= r_left) && (13'(i_column) < w_right) &&
                      (i_row >= r_top) && (13'(i_row) < w_bottom);

    logic [27:0] w_sum_add;
    assign w_sum_add = 28'(r_sum) + 28'(i_pixel_value);

    // histogram
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [HW-1:0] w_wdata, w_rdata;

    assign w_raddr = i_cmd.walk ? r_wcnt : i_pixel_value;
    assign w_waddr = i_cmd.walk ? r_wcnt : r_pix;
    assign w_we    = i_cmd.walk || (i_cmd.hist_wr && r_mask);
    assign w_wdata = i_cmd.walk ? '0 :
                     ((w_rdata == atf_pkg::CNT_MAX) ? w_rdata : w_rdata + 1'b1);

    atf_ram #(
        .WIDTH (HW),
        .DEPTH (atf_pkg::HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic [19:0] w_area_add;
    assign w_area_add = 20'(r_area) + 20'(w_rdata);

    // divider
    logic [atf_pkg::DIV_NUM_W-1:0] w_dividend, w_quo;
    logic [atf_pkg::DIV_DEN_W-1:0] w_divisor;
    logic w_div_done;

    assign w_dividend = i_cmd.div_thr ?
        52'(r_bright) * 52'(BASE_THRESHOLD) :
        ({25'd0, r_sum} << 24) + 52'(r_count[18:1]);
    assign w_divisor = i_cmd.div_thr ? r_base : 32'(r_count);

    atf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // shared multiplier
    logic [16:0] w_alpha;
    logic signed [35:0] w_ma;
    logic signed [24:0] w_mb;
    assign w_alpha = (r_alpha > atf_pkg::ONE_Q16) ? atf_pkg::ONE_Q16 : r_alpha;

    always_comb begin
        unique case (i_cmd.mul_sel)
            atf_pkg::MUL_EMA_OLD: begin
                w_ma = {4'd0, r_bright};
                w_mb = 25'(atf_pkg::EMA_KEEP);
            end
            atf_pkg::MUL_EMA_NEW: begin
                w_ma = {2'd0, w_quo[33:0]};
                w_mb = 25'(atf_pkg::EMA_WEIGHT);
            end
            atf_pkg::MUL_AREA_NEW: begin
                w_ma = 36'(r_area);
                w_mb = 25'(w_alpha);
            end
            atf_pkg::MUL_AREA_OLD: begin
                w_ma = {1'b0, r_mem_area};
                w_mb = 25'(atf_pkg::ONE_Q16 - w_alpha);
            end
            atf_pkg::MUL_K_HI: begin
                w_ma = 36'(r_gain);
                w_mb = 25'(r_mem_area[34:24]);
            end
            atf_pkg::MUL_K_LO: begin
                w_ma = 36'(r_gain);
                w_mb = {1'b0, r_mem_area[23:0]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // frame-end arithmetic
    logic [63:0] w_ema_sum, w_sm_sum;
    logic [31:0] w_nb;
    logic [7:0]  w_seen;
    logic signed [63:0] w_force;
    logic signed [47:0] w_force_sat;

    assign w_ema_sum = 64'(r_acc) + 64'(r_prod) + 64'h80_0000;
    assign w_nb      = w_ema_sum[55:24];
    assign w_seen    = (r_seen == 8'hFF) ? r_seen : r_seen + 1'b1;
    assign w_sm_sum  = 64'(r_acc) + 64'(r_prod) + 64'h8000;
    assign w_force   = r_acc + 64'(r_prod >>> 24) + 64'(r_offset);

    always_comb begin
        priority if (w_force > 64'sh7FFF_FFFF_FFFF) begin
            w_force_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (w_force < -64'sh8000_0000_0000) begin
            w_force_sat = 48'sh8000_0000_0000;
        end else begin
            w_force_sat = w_force[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= 10'd5;
            r_top      <= 9'd5;
            r_width    <= 10'd30;
            r_height   <= 9'd30;
            r_alpha    <= atf_pkg::ONE_Q16;
            r_gain     <= 32'sd6553600;
            r_offset   <= 32'sd25600;
            r_sum      <= '0;
            r_count    <= '0;
            r_bright   <= '0;
            r_base     <= '0;
            r_known    <= 1'b0;
            r_seen     <= '0;
            r_thr      <= 8'(BASE_THRESHOLD);
            r_mem_area <= '0;
            r_wcnt     <= '0;
            r_acc_on   <= 1'b0;
            r_fend     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (atf_pkg::t_cfg_idx'(i_cfg_index))
                    atf_pkg::CFG_ROI_LEFT:   r_left   <= i_cfg_data[9:0];
                    atf_pkg::CFG_ROI_TOP:    r_top    <= i_cfg_data[8:0];
                    atf_pkg::CFG_ROI_WIDTH:  r_width  <= i_cfg_data[9:0];
                    atf_pkg::CFG_ROI_HEIGHT: r_height <= i_cfg_data[8:0];
                    atf_pkg::CFG_BASELINE: begin
                        r_base   <= i_cfg_data;
                        r_known  <= i_cfg_data != '0;
                        r_seen   <= (i_cfg_data != '0) ?
                                    8'(WARMUP_FRAMES) : 8'd0;
                    end
                    atf_pkg::CFG_AREA_ALPHA: r_alpha  <= i_cfg_data[16:0];
                    atf_pkg::CFG_GAIN_K:     r_gain   <= i_cfg_data;
                    atf_pkg::CFG_OFFSET_B:   r_offset <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_fend <= i_frame_end;
                if (w_in_win) begin
                    r_sum   <= (w_sum_add > 28'(atf_pkg::SUM_MAX)) ?
                               atf_pkg::SUM_MAX : w_sum_add[26:0];
                    r_count <= (r_count == atf_pkg::CNT_MAX) ?
                               r_count : r_count + 1'b1;
                end
            end
            if (i_cmd.frame_clr) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if (i_cmd.ema_upd) begin
                r_bright <= w_nb;
                if (!r_known) begin
                    r_seen <= w_seen;
                    if (w_seen >= 8'(WARMUP_FRAMES)) begin
                        r_base  <= w_nb;
                        r_known <= 1'b1;
                    end
                end
            end
            if (i_cmd.thr_upd) begin
                priority if (w_quo < 52'(atf_pkg::THRESH_MIN)) begin
                    r_thr <= atf_pkg::THRESH_MIN;
                end else if (w_quo > 52'(atf_pkg::THRESH_MAX)) begin
                    r_thr <= atf_pkg::THRESH_MAX;
                end else begin
                    r_thr <= w_quo[7:0];
                end
            end
            if (i_cmd.sm_upd) begin
                r_mem_area <= w_sm_sum[50:16];
            end
            if (i_cmd.walk) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            r_acc_on <= i_cmd.walk && i_cmd.walk_sum;
        end
    end

    // payload, product, accumulator, area and output registers (no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix  <= i_pixel_value;
            r_mask <= i_inside_mask;
        end
        r_prev <= r_wcnt;
        r_prod <= w_ma * w_mb;
        if (i_cmd.acc_load) begin
            r_acc <= i_cmd.acc_shift ? (64'(r_prod) << 16) : 64'(r_prod);
        end
        if (i_cmd.area_clr) begin
            r_area <= '0;
        end else if (r_acc_on && (r_prev > r_thr)) begin
            r_area <= w_area_add[19] ? atf_pkg::CNT_MAX : w_area_add[18:0];
        end
        if (i_cmd.f_upd) begin
            r_o_area   <= r_area;
            r_o_sm     <= r_mem_area;
            r_o_force  <= w_force_sat;
            r_o_thr    <= r_thr;
            r_o_bright <= r_bright;
            r_o_known  <= r_known;
        end
    end

    assign o_status.fend      = r_fend;
    assign o_status.count_nz  = r_count != '0;
    assign o_status.thr_go    = r_known && (r_base != '0);
    assign o_status.div_done  = w_div_done;
    assign o_status.walk_last = r_wcnt == '1;

    assign o_area_count     = r_o_area;
    assign o_smoothed_area  = r_o_sm;
    assign o_force_value    = r_o_force;
    assign o_threshold_used = r_o_thr;
    assign o_brightness     = r_o_bright;
    assign o_baseline_ready = r_o_known;

endmodule

>>> hdl/atf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atf_ctrl
// Controller: pixel handshake, frame-end sequence and histogram sweeps.
// ----------------------------------------------------------------------------
module atf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  atf_pkg::t_status i_status,
    output atf_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_HIST, S_MEAN_GO, S_MEAN_WAIT, S_EMA1, S_EMA2, S_EMA3,
        S_THR_GO, S_THR_WAIT, S_WALK, S_WALK_END, S_SM1, S_SM2, S_SM3,
        S_F1, S_F2, S_F3, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = S_HIST;
            end
            S_HIST: begin
                o_cmd.hist_wr  = 1'b1;
                o_cmd.area_clr = 1'b1;
                priority if (!i_status.fend) n_state = S_IDLE;
                else if (i_status.count_nz) n_state = S_MEAN_GO;
                else n_state = S_WALK;
            end
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_status.div_done) n_state = S_EMA1;
            end
            S_EMA1: begin
                o_cmd.mul_sel = atf_pkg::MUL_EMA_OLD;
                n_state = S_EMA2;
            end
            S_EMA2: begin
                o_cmd.mul_sel  = atf_pkg::MUL_EMA_NEW;
                o_cmd.acc_load = 1'b1;
                n_state = S_EMA3;
            end
            S_EMA3: begin
                o_cmd.ema_upd = 1'b1;
                n_state = S_THR_GO;
            end
            S_THR_GO: begin
                o_cmd.div_thr   = 1'b1;
                o_cmd.div_start = i_status.thr_go;
                n_state = i_status.thr_go ? S_THR_WAIT : S_WALK;
            end
            S_THR_WAIT: begin
                o_cmd.thr_upd = i_status.div_done;
                if (i_status.div_done) n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk     = 1'b1;
                o_cmd.walk_sum = 1'b1;
                if (i_status.walk_last) n_state = S_WALK_END;
            end
            S_WALK_END: n_state = S_SM1;
            S_SM1: begin
                o_cmd.mul_sel   = atf_pkg::MUL_AREA_NEW;
                o_cmd.frame_clr = 1'b1;
                n_state = S_SM2;
            end
            S_SM2: begin
                o_cmd.mul_sel   = atf_pkg::MUL_AREA_OLD;
                o_cmd.acc_load  = 1'b1;
                o_cmd.acc_shift = 1'b1;
                n_state = S_SM3;
            end
            S_SM3: begin
                o_cmd.sm_upd = 1'b1;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd.mul_sel = atf_pkg::MUL_K_HI;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd.mul_sel  = atf_pkg::MUL_K_LO;
                o_cmd.acc_load = 1'b1;
                n_state = S_F3;
            end
            S_F3: begin
                o_cmd.f_upd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;

    a_accept_to_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_HIST))
        else $error("accepted pixel did not reach histogram update");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while result pending");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_MEAN_WAIT || r_state == S_THR_WAIT))
        else $error("divider finished outside a wait state");
    a_walk_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_status.walk_last) |=> (r_state == S_WALK_END))
        else $error("histogram sweep did not end");

endmodule

>>> hdl/adaptive_threshold_area_force_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_threshold_area_force_unit
// Pixel-area force sensor with adaptive binary threshold.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid/o_ready) takes one pixel per transfer with its
//    column, row, mask bit and frame-end mark. The pixel's histogram bin is
//    read when it is accepted and written back before the next pixel is taken.
//  - On the frame-end pixel the block runs its frame sequence: a divide for
//    the window mean, the brightness update and an optional divide for the
//    threshold (all three skipped if the window is empty), a histogram sweep
//    that counts and clears the bins, then area smoothing and force.
//  - Output channel (o_valid/i_ready) presents one result per frame; it is
//    held until transferred and no pixel is taken meanwhile.
//  - Reset runs a clearing pass over the histogram with o_ready
//    low; configuration writes are taken at any time.
//  - Write configuration only while idle.
// ----------------------------------------------------------------------------
module adaptive_threshold_area_force_unit #(
    parameter int FRAME_WIDTH    = atf_pkg::FRAME_WIDTH,
    parameter int FRAME_HEIGHT   = atf_pkg::FRAME_HEIGHT,
    parameter int WARMUP_FRAMES  = atf_pkg::WARMUP_FRAMES,
    parameter int BASE_THRESHOLD = atf_pkg::BASE_THRESHOLD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_pixel_value,
    input  logic [9:0]         i_column,
    input  logic [8:0]         i_row,
    input  logic               i_inside_mask,
    input  logic               i_frame_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [18:0]        o_area_count,
    output logic [34:0]        o_smoothed_area,
    output logic signed [47:0] o_force_value,
    output logic [7:0]         o_threshold_used,
    output logic [31:0]        o_brightness,
    output logic               o_baseline_ready
);

    atf_pkg::t_cmd    w_cmd;
    atf_pkg::t_status w_status;

    atf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    atf_dp #(
        .FRAME_WIDTH    (FRAME_WIDTH),
        .FRAME_HEIGHT   (FRAME_HEIGHT),
        .WARMUP_FRAMES  (WARMUP_FRAMES),
        .BASE_THRESHOLD (BASE_THRESHOLD)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pixel_value    (i_pixel_value),
        .i_column         (i_column),
        .i_row            (i_row),
        .i_inside_mask    (i_inside_mask),
        .i_frame_end      (i_frame_end),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_area_count     (o_area_count),
        .o_smoothed_area  (o_smoothed_area),
        .o_force_value    (o_force_value),
        .o_threshold_used (o_threshold_used),
        .o_brightness     (o_brightness),
        .o_baseline_ready (o_baseline_ready)
    );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the adaptive threshold area force unit against a cycle-free
// predictor. Short frames are streamed through the pixel channel under
// several idle patterns and register settings. Every frame-end result is
// compared field by field with the predicted one.
// ----------------------------------------------------------------------------

typedef struct {
    logic [18:0]        area;
    logic [34:0]        smoothed;
    logic signed [47:0] frc;
    logic [7:0]         thresh;
    logic [31:0]        bright;
    logic               ready;
} t_frame_result;

class area_force_scoreboard;
    int unsigned     roi_left, roi_top, roi_width, roi_height;
    int unsigned     preset, alpha;
    longint          gain, offset;
    int unsigned     hist [256];
    int unsigned     wsum, wcnt;
    longint unsigned fbright, base;
    bit              known;
    int unsigned     warm, thr;
    longint unsigned mem;
    t_frame_result   pending [$];
    int              errors;

    function new();
        roi_left = 5; roi_top = 5; roi_width = 30; roi_height = 30;
        alpha = 65536; gain = 6553600; offset = 25600;
        foreach (hist[i]) hist[i] = 0;
        wsum = 0; wcnt = 0; fbright = 0; thr = atf_pkg::BASE_THRESHOLD; mem = 0;
        errors = 0;
        load_preset(0);
    endfunction

    function void load_preset(int unsigned v);
        preset = v;
        base   = v;
        known  = (v != 0);
        warm   = known ? atf_pkg::WARMUP_FRAMES : 0;
    endfunction

    function void write_reg(atf_pkg::t_cfg_idx idx, logic [31:0] d);
        case (idx)
            atf_pkg::CFG_ROI_LEFT:   roi_left   = d[9:0];
            atf_pkg::CFG_ROI_TOP:    roi_top    = d[8:0];
            atf_pkg::CFG_ROI_WIDTH:  roi_width  = d[9:0];
            atf_pkg::CFG_ROI_HEIGHT: roi_height = d[8:0];
            atf_pkg::CFG_BASELINE:   load_preset(d);
            atf_pkg::CFG_AREA_ALPHA: alpha      = d[16:0];
            atf_pkg::CFG_GAIN_K:     gain       = longint'(signed'(d));
            atf_pkg::CFG_OFFSET_B:   offset     = longint'(signed'(d));
            default: ;
        endcase
    endfunction

    function void predict_frame_end();
        longint unsigned mean, nb, t, acc, a, m;
        longint          hi, lo, f;
        t_frame_result   r;
        if (wcnt != 0) begin
            mean = ((longint'(wsum) << 24) + (wcnt >> 1)) / wcnt;
            nb = (fbright * (64'd16777216 - 64'd4664) + mean * 64'd4664
                  + 64'd8388608) >> 24;
            fbright = nb & 64'hFFFF_FFFF;
            if (!known) begin
                if (warm < 255) warm++;
                if (warm >= atf_pkg::WARMUP_FRAMES) begin
                    base  = fbright;
                    known = 1;
                end
            end
            if (known && base != 0) begin
                t = (64'(atf_pkg::BASE_THRESHOLD) * fbright) / base;
                if (t < atf_pkg::THRESH_MIN) t = atf_pkg::THRESH_MIN;
                if (t > atf_pkg::THRESH_MAX) t = atf_pkg::THRESH_MAX;
                thr = t[31:0];
            end
        end
        acc = 0;
        for (int v = thr + 1; v < 256; v++) acc += hist[v];
        if (acc > 524287) acc = 524287;
        a = (alpha > 65536) ? 65536 : alpha;
        m = (a * (acc << 16) + (65536 - a) * mem + 32768) >> 16;
        mem = m & 64'h7_FFFF_FFFF;
        hi = longint'(mem >> 24);
        lo = longint'(mem & 64'hFF_FFFF);
        f = gain * hi + ((gain * lo) >>> 24) + offset;
        if (f > 64'sd140737488355327) f = 64'sd140737488355327;
        if (f < -64'sd140737488355328) f = -64'sd140737488355328;
        r.area = acc[18:0]; r.smoothed = mem[34:0]; r.frc = f[47:0];
        r.thresh = thr[7:0]; r.bright = fbright[31:0]; r.ready = known;
        pending.insert(pending.size(), r);
        foreach (hist[i]) hist[i] = 0;
        wsum = 0; wcnt = 0;
    endfunction

    function void note_pixel(int unsigned pix, int unsigned col, int unsigned row,
                             bit mask, bit fend);
        int unsigned right, bottom;
        right  = roi_left + roi_width;
        bottom = roi_top + roi_height;
        if (right > atf_pkg::FRAME_WIDTH) right = atf_pkg::FRAME_WIDTH;
        if (bottom > atf_pkg::FRAME_HEIGHT) bottom = atf_pkg::FRAME_HEIGHT;
        if (col >= roi_left && col < right && row >= roi_top && row < bottom) begin
            wsum = (wsum + pix > atf_pkg::SUM_MAX) ? atf_pkg::SUM_MAX : wsum + pix;
            if (wcnt < atf_pkg::CNT_MAX) wcnt++;
        end
        if (mask && hist[pix] < atf_pkg::CNT_MAX) hist[pix]++;
        if (fend) predict_frame_end();
    endfunction

    function void check_result(t_frame_result got);
        t_frame_result e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, area %0d force %0d", $time,
                     got.area, got.frc);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.area !== e.area) begin
            $display("%0t: area exp %0d got %0d", $time, e.area, got.area);
            errors++;
        end
        if (got.smoothed !== e.smoothed) begin
            $display("%0t: smoothed exp %0d got %0d", $time, e.smoothed, got.smoothed);
            errors++;
        end
        if (got.frc !== e.frc) begin
            $display("%0t: force exp %0d got %0d", $time, e.frc, got.frc);
            errors++;
        end
        if (got.thresh !== e.thresh) begin
            $display("%0t: threshold exp %0d got %0d", $time, e.thresh, got.thresh);
            errors++;
        end
        if (got.bright !== e.bright) begin
            $display("%0t: brightness exp %0h got %0h", $time, e.bright, got.bright);
            errors++;
        end
        if (got.ready !== e.ready) begin
            $display("%0t: baseline ready exp %0b got %0b", $time, e.ready, got.ready);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_pixel_value;
    logic [9:0]         i_column;
    logic [8:0]         i_row;
    logic               i_inside_mask;
    logic               i_frame_end;
    logic               o_valid;
    logic               i_ready;
    logic [18:0]        o_area_count;
    logic [34:0]        o_smoothed_area;
    logic signed [47:0] o_force_value;
    logic [7:0]         o_threshold_used;
    logic [31:0]        o_brightness;
    logic               o_baseline_ready;

    area_force_scoreboard sb;
    int                   tx_idle_pct;
    int                   rx_stall_pct;
    int                   rx_hold;

    adaptive_threshold_area_force_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_ready = 1'b0;
                rx_hold--;
            end else begin
                i_ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.area = o_area_count; got.smoothed = o_smoothed_area;
            got.frc = o_force_value; got.thresh = o_threshold_used;
            got.bright = o_brightness; got.ready = o_baseline_ready;
            sb.check_result(got);
        end
    end

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
            default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
        endcase
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_pixel(int unsigned pix, int unsigned col, int unsigned row,
                              bit mask, bit fend);
        i_pixel_value = pix[7:0]; i_column = col[9:0]; i_row = row[8:0];
        i_inside_mask = mask; i_frame_end = fend;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(pix, col, row, mask, fend);
        @(negedge i_clk);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(atf_pkg::t_cfg_idx idx, logic [31:0] d);
        i_cfg_wr_en = 1'b1; i_cfg_index = idx; i_cfg_data = d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // one frame of n pixels, mostly inside the window
    task automatic random_frame(int n);
        int unsigned col, row;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 70) begin
                col = sb.roi_left + $urandom_range(0, sb.roi_width);
                row = sb.roi_top + $urandom_range(0, sb.roi_height);
                if (col > 1023) col = 1023;
                if (row > 511) row = 511;
            end else begin
                col = $urandom_range(0, 1023);
                row = $urandom_range(0, 511);
            end
            send_pixel($urandom_range(0, 255), col, row, $urandom_range(0, 1),
                       i == n - 1);
        end
    endtask

    // preset that puts the threshold somewhere around the clamp window
    function automatic logic [31:0] preset_near_brightness();
        longint unsigned p;
        if (sb.fbright == 0) return $urandom_range(1, 1000);
        p = (sb.fbright * 120) / $urandom_range(60, 200);
        return (p == 0) ? 32'd1 : p[31:0];
    endfunction

    task automatic random_config();
        write_cfg(atf_pkg::CFG_ROI_LEFT, $urandom_range(0, 40));
        write_cfg(atf_pkg::CFG_ROI_TOP, $urandom_range(0, 40));
        write_cfg(atf_pkg::CFG_ROI_WIDTH, $urandom_range(0, 60));
        write_cfg(atf_pkg::CFG_ROI_HEIGHT, $urandom_range(0, 60));
        if ($urandom_range(3) != 0)
            write_cfg(atf_pkg::CFG_BASELINE, preset_near_brightness());
        write_cfg(atf_pkg::CFG_AREA_ALPHA,
                  $urandom_range(0, 3) == 0 ? $urandom_range(65536, 131071)
                                            : $urandom_range(0, 65536));
        write_cfg(atf_pkg::CFG_GAIN_K, $urandom());
        write_cfg(atf_pkg::CFG_OFFSET_B, $urandom());
    endtask

    initial begin
        sb = new();
        tx_idle_pct = 0; rx_stall_pct = 0; rx_hold = 0;
        i_rst_n = 1'b0; i_cfg_wr_en = 1'b0; i_cfg_index = atf_pkg::CFG_ROI_LEFT;
        i_cfg_data = '0; i_valid = 1'b0; i_pixel_value = '0; i_column = '0;
        i_row = '0; i_inside_mask = 1'b0; i_frame_end = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // warmup on a black window: the learned baseline ends up zero
        set_idling(0);
        for (int f = 0; f < 205; f++) begin
            if ($urandom_range(3) == 0)
                send_pixel($urandom_range(0, 255), $urandom_range(40, 1023),
                           $urandom_range(0, 511), 1'b1, 1'b0);
            send_pixel(0, 5 + $urandom_range(0, 29), 5 + $urandom_range(0, 29),
                       $urandom_range(0, 1), 1'b1);
        end
        wait_drained();

        // directed: field extremes, pixels outside the frame, empty window
        send_pixel(0, 5, 5, 1, 0);
        send_pixel(255, 34, 34, 1, 0);
        send_pixel(255, 0, 0, 1, 0);
        send_pixel(128, 639, 479, 1, 0);
        send_pixel(200, 1023, 511, 1, 0);
        send_pixel(77, 35, 5, 0, 0);
        send_pixel(255, 5, 35, 1, 1);
        send_pixel(255, 0, 0, 1, 0);
        send_pixel(100, 1023, 511, 1, 1);
        send_pixel(10, 10, 10, 0, 1);
        wait_drained();
        write_cfg(atf_pkg::CFG_BASELINE, 32'd1);
        write_cfg(atf_pkg::CFG_AREA_ALPHA, 32'd0);
        write_cfg(atf_pkg::CFG_GAIN_K, 32'h7FFF_FFFF);
        write_cfg(atf_pkg::CFG_OFFSET_B, 32'h8000_0000);
        send_pixel(255, 10, 10, 1, 0);
        send_pixel(181, 11, 11, 1, 1);
        wait_drained();
        write_cfg(atf_pkg::CFG_BASELINE, 32'hFFFF_FFFF);
        write_cfg(atf_pkg::CFG_AREA_ALPHA, 32'h1FFFF);
        write_cfg(atf_pkg::CFG_GAIN_K, 32'h8000_0000);
        write_cfg(atf_pkg::CFG_OFFSET_B, 32'h7FFF_FFFF);
        write_cfg(atf_pkg::CFG_ROI_LEFT, 32'd639);
        write_cfg(atf_pkg::CFG_ROI_TOP, 32'd479);
        write_cfg(atf_pkg::CFG_ROI_WIDTH, 32'd640);
        write_cfg(atf_pkg::CFG_ROI_HEIGHT, 32'd480);
        send_pixel(81, 639, 479, 1, 0);
        send_pixel(255, 639, 479, 1, 1);
        wait_drained();
        write_cfg(atf_pkg::CFG_ROI_LEFT, 32'd0);
        write_cfg(atf_pkg::CFG_ROI_TOP, 32'd0);
        write_cfg(atf_pkg::CFG_ROI_WIDTH, 32'd0);
        write_cfg(atf_pkg::CFG_ROI_HEIGHT, 32'd0);
        send_pixel(90, 0, 0, 1, 1);
        wait_drained();

        // restart warmup with a live window and learn a real baseline
        write_cfg(atf_pkg::CFG_ROI_LEFT, 32'd5);
        write_cfg(atf_pkg::CFG_ROI_TOP, 32'd5);
        write_cfg(atf_pkg::CFG_ROI_WIDTH, 32'd30);
        write_cfg(atf_pkg::CFG_ROI_HEIGHT, 32'd30);
        write_cfg(atf_pkg::CFG_BASELINE, 32'd0);
        write_cfg(atf_pkg::CFG_AREA_ALPHA, 32'd32768);
        write_cfg(atf_pkg::CFG_GAIN_K, 32'd6553600);
        write_cfg(atf_pkg::CFG_OFFSET_B, 32'd25600);
        set_idling(1);
        for (int f = 0; f < 202; f++)
            send_pixel($urandom_range(0, 255), 5 + $urandom_range(0, 29),
                       5 + $urandom_range(0, 29), $urandom_range(0, 1), 1'b1);
        wait_drained();

        // random phases under each idle pattern
        for (int ph = 0; ph < 12; ph++) begin
            random_config();
            set_idling(ph + 2);
            for (int f = 0; f < 6; f++) begin
                random_frame($urandom_range(1, 6));
                if (f == 3) wait_drained();
            end
            wait_drained();
        end

        // long receiver hold-off while the sender keeps offering frames
        set_idling(0);
        rx_hold = 3000;
        for (int f = 0; f < 6; f++) random_frame($urandom_range(2, 6));
        wait_drained();

        repeat (400) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
